@@ hdl/rbox_pkg.sv @@
// shared types, constants and sizes of the rgb 3x3 box smoothing block
package rbox_pkg;

  // frame geometry
  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int CHANNEL_BITS = 8;
  localparam int CFG_BITS     = 11;
  localparam int POS_BITS     = 10;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
  localparam int EW_BITS      = ($clog2(MAX_WIDTH + 1) > CFG_BITS) ?
                                $clog2(MAX_WIDTH + 1) : CFG_BITS;
  localparam int EH_BITS      = ($clog2(HEIGHT_LIMIT + 1) > CFG_BITS) ?
                                $clog2(HEIGHT_LIMIT + 1) : CFG_BITS;

  // register reset values
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

  // register index
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // averaging arithmetic: divide by nine through a scaled reciprocal
  localparam int CHAN_MAX    = (1 << CHANNEL_BITS) - 1;
  localparam int NEIGHBORS   = 9;
  localparam int COLSUM_BITS = $clog2(3 * CHAN_MAX + 1);
  localparam int SUM_BITS    = $clog2(NEIGHBORS * CHAN_MAX + 1);
  localparam int DIV_SHIFT   = 16;
  localparam int DIV_MUL     = ((1 << DIV_SHIFT) + NEIGHBORS - 1) / NEIGHBORS;
  localparam int PROD_BITS   = SUM_BITS + DIV_SHIFT;

  // result slots of one item, in release order
  typedef enum logic [2:0] {
    SLOT_NONE   = 3'b000,
    SLOT_WINDOW = 3'b001,
    SLOT_ROWEND = 3'b010,
    SLOT_SELF   = 3'b100
  } slot_e;

  // one pixel, red in the low bits
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;
  } pix_t;

  // per-channel sum of one window column
  typedef struct packed {
    logic [COLSUM_BITS-1:0] blue;
    logic [COLSUM_BITS-1:0] green;
    logic [COLSUM_BITS-1:0] red;
  } csum_t;

  localparam int LINE_BITS = 2 * $bits(pix_t);

endpackage

@@ hdl/rbox_if.sv @@
// valid/ready channels for incoming pixels and released results
interface rbox_pix_if;
  logic                              valid;
  logic                              ready;
  logic [rbox_pkg::CHANNEL_BITS-1:0] in_red;
  logic [rbox_pkg::CHANNEL_BITS-1:0] in_green;
  logic [rbox_pkg::CHANNEL_BITS-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface rbox_res_if;
  logic                              valid;
  logic                              ready;
  logic [rbox_pkg::CHANNEL_BITS-1:0] out_red;
  logic [rbox_pkg::CHANNEL_BITS-1:0] out_green;
  logic [rbox_pkg::CHANNEL_BITS-1:0] out_blue;
  logic [rbox_pkg::POS_BITS-1:0]     out_row;
  logic [rbox_pkg::POS_BITS-1:0]     out_col;
  logic                              run_last;
  logic                              frame_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output run_last,
                  output frame_last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_col, input run_last,
                  input frame_last, output ready);
endinterface

@@ hdl/rbox_ram.sv @@
// generic single-port-write ram with registered read
module rbox_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rbox_mean.sv @@
// column sum and 3x3 mean per channel from two stored column sums
module rbox_mean (
  input  rbox_pkg::csum_t csum0_i,
  input  rbox_pkg::csum_t csum1_i,
  input  rbox_pkg::pix_t  top_i,
  input  rbox_pkg::pix_t  mid_i,
  input  rbox_pkg::pix_t  bot_i,
  output rbox_pkg::csum_t csum_o,
  output rbox_pkg::pix_t  mean_o
);
  import rbox_pkg::*;

  // sum of three channel values of one column
  function automatic logic [COLSUM_BITS-1:0] col3(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b,
    input logic [CHANNEL_BITS-1:0] c
  );
    return COLSUM_BITS'(a) + COLSUM_BITS'(b) + COLSUM_BITS'(c);
  endfunction

  // truncated mean of three column sums: multiply by reciprocal of nine
  function automatic logic [CHANNEL_BITS-1:0] div9(
    input logic [COLSUM_BITS-1:0] s0,
    input logic [COLSUM_BITS-1:0] s1,
    input logic [COLSUM_BITS-1:0] s2
  );
    logic [SUM_BITS-1:0]  sum;
    logic [PROD_BITS-1:0] prod;
    sum  = SUM_BITS'(s0) + SUM_BITS'(s1) + SUM_BITS'(s2);
    prod = PROD_BITS'(sum) * PROD_BITS'(DIV_MUL);
    return prod[DIV_SHIFT +: CHANNEL_BITS];
  endfunction

  // current column
  assign csum_o.red   = col3(top_i.red,   mid_i.red,   bot_i.red);
  assign csum_o.green = col3(top_i.green, mid_i.green, bot_i.green);
  assign csum_o.blue  = col3(top_i.blue,  mid_i.blue,  bot_i.blue);

  // whole window
  assign mean_o.red   = div9(csum_o.red,   csum0_i.red,   csum1_i.red);
  assign mean_o.green = div9(csum_o.green, csum0_i.green, csum1_i.green);
  assign mean_o.blue  = div9(csum_o.blue,  csum0_i.blue,  csum1_i.blue);

endmodule

@@ hdl/rgb_box_smoothing_3x3_core.sv @@
// top level of the streaming rgb 3x3 box smoothing block
// Takes one raster-order pixel per cycle while each pixel releases at most one
// result and the output is not stalled, and releases results through an output
// register, each tagged with its row and column. Pixel (y, x) releases pixel
// (y-1, x-1), smoothed if interior and copied otherwise; at row end also
// (y-1, x); on the last row also a copy of itself. A pixel holds the input
// register until it has released all its results, since the output register
// moves one result a cycle: from the second row on a pixel past the first
// column releases one, a row end adds one and every pixel of the last row adds
// its own copy, so at most three. A pixel that releases nothing (the first row,
// unless the frame has a single row) leaves without waiting for the output. The
// two previous rows live in one ram read at the column of the accepted pixel;
// there is no clearing pass after reset.
// Write frame_width and frame_height only while no item is in flight.
module rgb_box_smoothing_3x3_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbox_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rbox_pkg::CFG_BITS-1:0]       cfg_data_i,
  rbox_pix_if.sink                            pix_i,
  rbox_res_if.source                          res_o
);
  import rbox_pkg::*;

  // configuration registers
  logic [CFG_BITS-1:0] width_q;
  logic [CFG_BITS-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  logic [EW_BITS-1:0] eff_w;
  logic [EH_BITS-1:0] eff_h;

  always_comb begin
    if (width_q == '0) begin
      eff_w = EW_BITS'(1);
    end else if (EW_BITS'(width_q) > EW_BITS'(MAX_WIDTH)) begin
      eff_w = EW_BITS'(MAX_WIDTH);
    end else begin
      eff_w = EW_BITS'(width_q);
    end
    if (height_q == '0) begin
      eff_h = EH_BITS'(1);
    end else if (EH_BITS'(height_q) > EH_BITS'(HEIGHT_LIMIT)) begin
      eff_h = EH_BITS'(HEIGHT_LIMIT);
    end else begin
      eff_h = EH_BITS'(height_q);
    end
  end

  // position counters and flags of the next pixel
  logic [COL_BITS-1:0] col_q, col_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [EW_BITS-1:0]  x_ext;
  logic [EH_BITS-1:0]  y_ext;
  logic                row_end, last_row, x_fits, y_fits, interior;
  logic [2:0]          mask;

  assign x_ext    = EW_BITS'(col_q);
  assign y_ext    = EH_BITS'(row_q);
  assign row_end  = x_ext >= eff_w - EW_BITS'(1);
  assign last_row = y_ext >= eff_h - EH_BITS'(1);
  assign x_fits   = (eff_w == EW_BITS'(1)) || (x_ext < eff_w);
  assign y_fits   = (eff_h == EH_BITS'(1)) || (y_ext < eff_h);
  assign interior = (x_ext >= EW_BITS'(2)) && (y_ext >= EH_BITS'(2)) && x_fits && y_fits;
  assign mask     = {last_row,
                     (row_q != '0) && row_end,
                     (row_q != '0) && (col_q != '0)};

  // handshake control
  logic accept, retire, load, out_free, is_last;
  logic s1_valid_q;
  logic [2:0] sent_q, sent_d, pending;
  slot_e      sel;

  assign pix_i.ready = !s1_valid_q || retire;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_BITS'(1);
      end else begin
        col_d = col_q + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // input register
  pix_t                s1_pix_q;
  logic [COL_BITS-1:0] s1_x_q;
  logic [ROW_BITS-1:0] s1_y_q;
  logic [2:0]          s1_mask_q;
  logic                s1_interior_q;
  logic                s1_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (retire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q       <= '{blue: pix_i.in_blue, green: pix_i.in_green, red: pix_i.in_red};
      s1_x_q         <= col_q;
      s1_y_q         <= row_q;
      s1_mask_q      <= mask;
      s1_interior_q  <= interior;
      s1_frame_end_q <= row_end && last_row;
    end
  end

  // line stores: {second previous row, previous row} at each column
  logic [LINE_BITS-1:0] line_rdata;
  pix_t                 col_top, col_mid;
  logic                 fwd_q;
  pix_t                 fwd_top_q, fwd_mid_q;

  rbox_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (retire),
    .waddr_i (s1_x_q),
    .wdata_i ({col_mid, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // bypass for a read of the column that retires in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= retire && (col_q == s1_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_top_q <= col_mid;
      fwd_mid_q <= s1_pix_q;
    end
  end

  assign col_top = fwd_q ? fwd_top_q : pix_t'(line_rdata[LINE_BITS-1 -: $bits(pix_t)]);
  assign col_mid = fwd_q ? fwd_mid_q : pix_t'(line_rdata[$bits(pix_t)-1:0]);

  // window of the two previous columns
  csum_t csum0_q, csum1_q, csum_new;
  pix_t  win_mid_q, mean;

  rbox_mean u_mean (
    .csum0_i (csum0_q),
    .csum1_i (csum1_q),
    .top_i   (col_top),
    .mid_i   (col_mid),
    .bot_i   (s1_pix_q),
    .csum_o  (csum_new),
    .mean_o  (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum0_q   <= '0;
      csum1_q   <= '0;
      win_mid_q <= '0;
    end else if (retire) begin
      csum1_q   <= csum0_q;
      csum0_q   <= csum_new;
      win_mid_q <= col_mid;
    end
  end

  // result release order: window pixel, row end, own copy
  assign pending = s1_valid_q ? (s1_mask_q & ~sent_q) : 3'b000;

  always_comb begin
    if (pending[0]) begin
      sel = SLOT_WINDOW;
    end else if (pending[1]) begin
      sel = SLOT_ROWEND;
    end else if (pending[2]) begin
      sel = SLOT_SELF;
    end else begin
      sel = SLOT_NONE;
    end
  end

  logic res_valid_q;

  assign out_free = !res_valid_q || res_o.ready;
  assign load     = (pending != 3'b000) && out_free;
  assign is_last  = (pending & ~sel) == 3'b000;
  assign retire   = s1_valid_q && ((pending == 3'b000) || (load && is_last));

  always_comb begin
    sent_d = sent_q;
    if (retire) begin
      sent_d = '0;
    end else if (load) begin
      sent_d = sent_q | sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
    end else begin
      sent_q <= sent_d;
    end
  end

  // selected result
  pix_t                res_pix;
  logic [POS_BITS-1:0] res_row, res_col;

  always_comb begin
    case (sel)
      SLOT_WINDOW: begin
        res_pix = s1_interior_q ? mean : win_mid_q;
        res_row = POS_BITS'(s1_y_q - ROW_BITS'(1));
        res_col = POS_BITS'(s1_x_q - COL_BITS'(1));
      end
      SLOT_ROWEND: begin
        res_pix = col_mid;
        res_row = POS_BITS'(s1_y_q - ROW_BITS'(1));
        res_col = POS_BITS'(s1_x_q);
      end
      default: begin
        res_pix = s1_pix_q;
        res_row = POS_BITS'(s1_y_q);
        res_col = POS_BITS'(s1_x_q);
      end
    endcase
  end

  // output register
  pix_t                res_pix_q;
  logic [POS_BITS-1:0] res_row_q, res_col_q;
  logic                res_run_last_q, res_frame_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_pix_q        <= res_pix;
      res_row_q        <= res_row;
      res_col_q        <= res_col;
      res_run_last_q   <= is_last;
      res_frame_last_q <= is_last && s1_frame_end_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.out_red    = res_pix_q.red;
  assign res_o.out_green  = res_pix_q.green;
  assign res_o.out_blue   = res_pix_q.blue;
  assign res_o.out_row    = res_row_q;
  assign res_o.out_col    = res_col_q;
  assign res_o.run_last   = res_run_last_q;
  assign res_o.frame_last = res_frame_last_q;

`ifndef SYNTHESIS
  // an accepted item sits in the input register next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item missing from input register");

  // no new item while the current one still owes a blocked result
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending != 3'b000 && !out_free) |-> !pix_i.ready)
    else $error("input taken while results are still owed");

  // only slots the item really has are marked as released
  a_sent_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sent_q & ~s1_mask_q) == 3'b000)
    else $error("released slot outside the item's result set");

  // the frame's final result closes its item's run
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_last) |-> res_o.run_last)
    else $error("frame end flagged on a result that is not last of its item");
`endif

endmodule

@@ tb/rgb_box_smoothing_3x3_core_test.sv @@
// testbench of the rgb 3x3 box smoothing core: directed and random frames, scoreboard check
`timescale 1ns / 1ps

module rgb_box_smoothing_3x3_core_test;
  import rbox_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 12;
  localparam int IDLE_PCT      = 13;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int REPORT_MAX    = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 110;

  // one released pixel as seen on the result channel
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [POS_BITS-1:0]     row;
    logic [POS_BITS-1:0]     col;
    logic                    run_last;
    logic                    frame_last;
  } px_res_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_BITS-1:0]     cfg_data;

  rbox_pix_if pix ();
  rbox_res_if res ();

  rgb_box_smoothing_3x3_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  // shadow of the filter state
  pix_t                line_prev_m  [MAX_WIDTH];
  pix_t                line_prev2_m [MAX_WIDTH];
  pix_t                win_m        [6];
  int unsigned         row_cnt;
  int unsigned         col_cnt;
  logic [CFG_BITS-1:0] width_reg;
  logic [CFG_BITS-1:0] height_reg;

  px_res_t     released_px_q [$];
  int unsigned px_sent;
  int unsigned px_checked;
  int unsigned frames_done;
  int unsigned interior_cnt;
  int unsigned mismatch_cnt;
  bit          no_idle;
  int unsigned hold_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("timeout: block stopped making progress");
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic px_res_t pos_res(input pix_t p, input int unsigned r,
                                      input int unsigned c);
    return {p.red, p.green, p.blue, POS_BITS'(r), POS_BITS'(c), 2'b00};
  endfunction

  // box filter step: expected results of one accepted pixel
  function automatic void box_filter_predict(input pix_t cur);
    int unsigned w, h, x, y, xi, n, i;
    int unsigned sum_r, sum_g, sum_b;
    pix_t        p1, p2, val;
    bit          row_end, last_row, interior;
    px_res_t     outs [3];
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    x = col_cnt;
    y = row_cnt;
    xi = x % MAX_WIDTH;
    p2 = line_prev2_m[xi];
    p1 = line_prev_m[xi];
    row_end = (x >= w - 1);
    last_row = (y >= h - 1);
    n = 0;
    // window center one column back
    if (y >= 1 && x >= 1) begin
      val = win_m[1];
      interior = x >= 2 && y >= 2 && x - 1 <= w - 2 && y - 1 <= h - 2;
      if (interior) begin
        sum_r = p2.red + p1.red + cur.red;
        sum_g = p2.green + p1.green + cur.green;
        sum_b = p2.blue + p1.blue + cur.blue;
        for (i = 0; i < 6; i++) begin
          sum_r += win_m[i].red;
          sum_g += win_m[i].green;
          sum_b += win_m[i].blue;
        end
        val.red   = CHANNEL_BITS'(sum_r / NEIGHBORS);
        val.green = CHANNEL_BITS'(sum_g / NEIGHBORS);
        val.blue  = CHANNEL_BITS'(sum_b / NEIGHBORS);
        interior_cnt++;
      end
      outs[n] = pos_res(val, y - 1, x - 1);
      n++;
    end
    // right border of the previous row
    if (y >= 1 && row_end) begin
      outs[n] = pos_res(p1, y - 1, x);
      n++;
    end
    // last row copies itself
    if (last_row) begin
      outs[n] = pos_res(cur, y, x);
      n++;
    end
    if (n > 0) begin
      outs[n-1].run_last = 1'b1;
      if (row_end && last_row) begin
        outs[n-1].frame_last = 1'b1;
        frames_done++;
      end
    end
    for (i = 0; i < n; i++) released_px_q.push_back(outs[i]);
    // shift line stores, window and counters
    line_prev2_m[xi] = p1;
    line_prev_m[xi] = cur;
    win_m[3] = win_m[0];
    win_m[4] = win_m[1];
    win_m[5] = win_m[2];
    win_m[0] = p2;
    win_m[1] = p1;
    win_m[2] = cur;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    if ($urandom_range(99) < 10) begin
      // saturated channels push the nine-value sum to its limits
      p.red   = $urandom_range(1) ? '1 : '0;
      p.green = $urandom_range(1) ? '1 : '0;
      p.blue  = $urandom_range(1) ? '1 : '0;
    end else begin
      p = $bits(pix_t)'($urandom);
    end
    return p;
  endfunction

  // input side: offer one item, random gaps before it
  task automatic send_pixel(input pix_t p);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.in_red   <= p.red;
    pix.in_green <= p.green;
    pix.in_blue  <= p.blue;
    do @(posedge clk_i); while (!pix.ready);
    box_filter_predict(p);
    px_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_run(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic send_to_frame_end();
    do send_pixel(rand_pixel()); while (row_cnt != 0 || col_cnt != 0);
  endtask

  // stop offering and let every expected result drain
  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(negedge clk_i);
    while (released_px_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_BITS'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_WIDTH) width_reg = CFG_BITS'(val);
    else height_reg = CFG_BITS'(val);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // one interior pixel among borders, channel extremes
  task automatic test_border_and_interior();
    pix_t p;
    int   i;
    set_frame(3, 3);
    for (i = 0; i < 9; i++) begin
      p.red   = (i == 8) ? 8'hff : 8'(i * 32);
      p.green = ~p.red;
      p.blue  = i[0] ? 8'hff : 8'h00;
      send_pixel(p);
    end
  endtask

  // zero sizes act as one; frames below three are copied
  task automatic test_narrow_frames();
    set_frame(0, 0);
    send_run(2);
    set_frame(2, 2);
    send_to_frame_end();
  endtask

  // oversized registers, then shrinking mid-frame
  task automatic test_register_extremes();
    set_frame(2047, 1);
    send_run(3);
    wait_idle();
    write_reg(CFG_WIDTH, MAX_WIDTH);
    send_run(1);
    wait_idle();
    write_reg(CFG_WIDTH, 5);
    send_to_frame_end();
    set_frame(2, 2047);
    send_run(4);
    wait_idle();
    write_reg(CFG_HEIGHT, 1);
    send_to_frame_end();
  endtask

  // back to back items and results, no stalls on either side
  task automatic test_full_rate();
    set_frame($urandom_range(3, 12), $urandom_range(3, 4));
    no_idle = 1'b1;
    repeat (4) begin
      send_to_frame_end();
      wait_idle();
      write_reg(CFG_WIDTH, $urandom_range(3, 12));
      write_reg(CFG_HEIGHT, $urandom_range(3, 4));
    end
    no_idle = 1'b0;
  endtask

  // long result hold while the input keeps offering
  task automatic test_output_stall();
    set_frame(10, 6);
    hold_left = HOLD_CYCLES;
    send_to_frame_end();
  endtask

  // input pause mid-frame until all results are out
  task automatic test_sender_pause();
    set_frame(8, 5);
    send_run(13);
    wait_idle();
    send_to_frame_end();
  endtask

  // random frames, some paused and shrunk mid-frame
  task automatic test_random_frames();
    int unsigned start, pick, w, h, weff, heff, area;
    start = px_sent;
    while (px_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        w = $urandom_range(3, 14);
        h = $urandom_range(3, 6);
      end else if (pick < 85) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 6);
      end else if (pick < 95) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(30, 64);
        h = $urandom_range(1, 3);
      end
      set_frame(w, h);
      weff = (w < 1) ? 1 : w;
      heff = (h < 1) ? 1 : h;
      area = weff * heff;
      if (area > 1 && $urandom_range(99) < 20) begin
        send_run($urandom_range(1, area - 1));
        wait_idle();
        if ($urandom_range(1)) write_reg(CFG_WIDTH, $urandom_range(0, weff));
        else write_reg(CFG_HEIGHT, $urandom_range(0, heff));
      end
      send_to_frame_end();
    end
  endtask

  // result side: random stalls, long hold on request
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else begin
        res.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    px_res_t got, want;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.out_red, res.out_green, res.out_blue, res.out_row, res.out_col,
             res.run_last, res.frame_last};
      if (released_px_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("%0t unexpected result: rgb %0d %0d %0d at (%0d,%0d) last %b frame %b",
                   $time, got.red, got.green, got.blue, got.row, got.col,
                   got.run_last, got.frame_last);
      end else begin
        want = released_px_q.pop_front();
        px_checked++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row !== want.row || got.col !== want.col ||
            got.run_last !== want.run_last || got.frame_last !== want.frame_last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t mismatch: expected rgb %0d %0d %0d at (%0d,%0d) last %b frame %b",
                     $time, want.red, want.green, want.blue, want.row, want.col,
                     want.run_last, want.frame_last);
            $display("%0t           actual   rgb %0d %0d %0d at (%0d,%0d) last %b frame %b",
                     $time, got.red, got.green, got.blue, got.row, got.col,
                     got.run_last, got.frame_last);
          end
        end
      end
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    int unsigned wait_cnt;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_WIDTH;
    cfg_data     = '0;
    pix.valid    = 1'b0;
    pix.in_red   = '0;
    pix.in_green = '0;
    pix.in_blue  = '0;
    no_idle      = 1'b0;
    hold_left    = 0;
    width_reg    = WIDTH_RESET;
    height_reg   = HEIGHT_RESET;
    row_cnt      = 0;
    col_cnt      = 0;
    px_sent      = 0;
    px_checked   = 0;
    frames_done  = 0;
    interior_cnt = 0;
    mismatch_cnt = 0;
    for (wait_cnt = 0; wait_cnt < MAX_WIDTH; wait_cnt++) begin
      line_prev_m[wait_cnt]  = '0;
      line_prev2_m[wait_cnt] = '0;
    end
    for (wait_cnt = 0; wait_cnt < 6; wait_cnt++) win_m[wait_cnt] = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_border_and_interior();
    test_narrow_frames();
    test_register_extremes();
    test_full_rate();
    test_output_stall();
    test_sender_pause();
    test_random_frames();

    pix.valid <= 1'b0;
    for (wait_cnt = 0; wait_cnt < DRAIN_LIMIT && released_px_q.size() != 0; wait_cnt++)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (released_px_q.size() != 0) begin
      $display("%0d expected results never arrived", released_px_q.size());
      mismatch_cnt += released_px_q.size();
    end

    $display("covered border copies, interior means, frames of 1 to 64 columns, oversized");
    $display("and shrunk registers, output hold and input pauses: %0d pixels, %0d results,",
             px_sent, px_checked);
    $display("%0d frames closed, %0d interior means, %0d mismatches",
             frames_done, interior_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ rgb_box_smoothing_3x3_core.f @@
hdl/rbox_pkg.sv
hdl/rbox_if.sv
hdl/rbox_ram.sv
hdl/rbox_mean.sv
hdl/rgb_box_smoothing_3x3_core.sv
tb/rgb_box_smoothing_3x3_core_test.sv
